// ===== rtl/core/complex_arithmetic_unit_macros.svh =====
// Assertion macros for the complex arithmetic unit checker.
// Used by cau_checker; no other dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Checked property, masked while reset is asserted
`define CAU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also sampled during reset
`define CAU_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cau_pkg.sv =====
// Shared types and defaults for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_SCALE = 3'd3,
    OP_CONJ  = 3'd4,
    OP_RECIP = 3'd5,
    OP_DIV   = 3'd6
  } op_t;

endpackage

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Complex ALU on signed fixed-point operands: add, sub, mul, scale, conj, recip, div.
// One item per cycle sustained while the output is not stalled.
// The depth is set by the restoring divider, one quotient bit per register stage.
// Every stage holds a valid bit; a stalled output lets bubbles ahead of it fill.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// Depends on cau_pkg.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // a_re, a_im, b_re, b_im, scale_factor
  input  logic [((5*WORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  // operation
  input  logic [2:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // result_re, result_im
  output logic [((2*WORD_WIDTH+7)/8)*8-1:0]        out_tdata,
  // overflow, divide_by_zero
  output logic [1:0]                               out_tuser
);

  localparam int W      = WORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int SW     = 2*W + 1;
  localparam int DW     = 2*W;
  localparam int NW     = (2*W + F > W + 2*F) ? 2*W + F : W + 2*F;
  localparam int RW     = (NW > DW + W) ? NW : DW + W;
  localparam int OUT_DW = ((2*W+7)/8)*8;

  localparam logic signed [SW-1:0] SAT_HI  = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO  = ~SAT_HI;
  localparam logic signed [SW-1:0] BIG_POS = {{(SW-W-1){1'b0}}, 1'b1, {W{1'b0}}};

  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic          re_neg;
    logic          im_neg;
    logic          re_big;
    logic          im_big;
    logic [RW-1:0] re_r;
    logic [RW-1:0] im_r;
    logic [W-1:0]  re_q;
    logic [W-1:0]  im_q;
    logic [DW-1:0] den;
    logic [SW-1:0] re_v;
    logic [SW-1:0] im_v;
  } dp_t;

  function automatic logic signed [SW-1:0] trunc_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] bias;
    bias = v[SW-1] ? {{(SW-F){1'b0}}, {F{1'b1}}} : '0;
    return (v + bias) >>> F;
  endfunction

  function automatic logic signed [SW-1:0] fin_f(input logic is_div, input logic dz,
                                                 input logic neg, input logic big,
                                                 input logic [W-1:0] q,
                                                 input logic signed [SW-1:0] v);
    logic signed [SW-1:0] qv;
    qv = $signed({{(SW-W){1'b0}}, q});
    if (!is_div) return v;
    if (dz) return '0;
    if (big) return neg ? -BIG_POS : BIG_POS;
    return neg ? -qv : qv;
  endfunction

  function automatic logic [W:0] sat_f(input logic signed [SW-1:0] v);
    if (v > SAT_HI) return {1'b1, SAT_HI[W-1:0]};
    if (v < SAT_LO) return {1'b1, SAT_LO[W-1:0]};
    return {1'b0, v[W-1:0]};
  endfunction

  // ready chain
  logic          rdy1, rdy2, rdy3, rdy_out;
  logic [W+1:0]  dp_rdy;

  // stage 1: operands
  logic                 s1_v_r;
  op_t                  s1_op_r;
  logic signed [W-1:0]  s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r, s1_sf_r;

  // stage 2: products
  logic                 s2_v_r;
  op_t                  s2_op_r;
  logic signed [W-1:0]  s2_ar_r, s2_ai_r, s2_br_r, s2_bi_r;
  logic signed [DW-1:0] s2_m0_r, s2_m1_r, s2_m2_r, s2_m3_r, s2_m4_r, s2_m5_r;
  logic signed [W-1:0]  m0x, m0y, m1x, m1y;

  // stage 3: sums
  logic                 s3_v_r;
  op_t                  s3_op_r;
  logic signed [SW-1:0] s3_re_r, s3_im_r, s3_re_nxt, s3_im_nxt, den_sum;
  logic [DW-1:0]        s3_den_r;

  // divider pipe
  logic [W+1:0]         dv_r;
  logic [W+1:0]         dv_prev;
  dp_t                  dp_r [W+2];
  dp_t                  dp0_nxt, dp1_nxt;

  // output
  logic                 out_v_r;
  logic [OUT_DW-1:0]    out_data_r;
  logic [1:0]           out_user_r;
  logic [W:0]           sat_re, sat_im;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r || dp_rdy[0];
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;

  for (genvar i = 0; i <= W + 1; i++) begin : g_rdy
    if (i == W + 1) begin : g_last
      assign dp_rdy[i] = !dv_r[i] || rdy_out;
    end else begin : g_mid
      assign dp_rdy[i] = !dv_r[i] || dp_rdy[i+1];
    end
  end

  // valid bits
  assign dv_prev = {dv_r[W:0], s3_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      dv_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_tvalid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      for (int i = 0; i <= W + 1; i++) begin
        if (dp_rdy[i]) dv_r[i] <= dv_prev[i];
      end
      if (rdy_out) out_v_r <= dv_r[W+1];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_op_r <= op_t'(in_tuser);
      s1_ar_r <= in_tdata[W-1:0];
      s1_ai_r <= in_tdata[2*W-1:W];
      s1_br_r <= in_tdata[3*W-1:2*W];
      s1_bi_r <= in_tdata[4*W-1:3*W];
      s1_sf_r <= in_tdata[5*W-1:4*W];
    end
  end

  // stage 2
  always_comb begin
    case (s1_op_r)
      OP_SCALE: begin
        m0x = s1_sf_r; m0y = s1_ar_r;
        m1x = s1_sf_r; m1y = s1_ai_r;
      end
      OP_RECIP: begin
        m0x = s1_ar_r; m0y = s1_ar_r;
        m1x = s1_ai_r; m1y = s1_ai_r;
      end
      default: begin
        m0x = s1_ar_r; m0y = s1_br_r;
        m1x = s1_ai_r; m1y = s1_bi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_op_r <= s1_op_r;
      s2_ar_r <= s1_ar_r;
      s2_ai_r <= s1_ai_r;
      s2_br_r <= s1_br_r;
      s2_bi_r <= s1_bi_r;
      s2_m0_r <= DW'(m0x) * DW'(m0y);
      s2_m1_r <= DW'(m1x) * DW'(m1y);
      s2_m2_r <= DW'(s1_ar_r) * DW'(s1_bi_r);
      s2_m3_r <= DW'(s1_ai_r) * DW'(s1_br_r);
      s2_m4_r <= DW'(s1_br_r) * DW'(s1_br_r);
      s2_m5_r <= DW'(s1_bi_r) * DW'(s1_bi_r);
    end
  end

  // stage 3
  always_comb begin
    case (s2_op_r)
      OP_ADD: begin
        s3_re_nxt = SW'(s2_ar_r) + SW'(s2_br_r);
        s3_im_nxt = SW'(s2_ai_r) + SW'(s2_bi_r);
      end
      OP_SUB: begin
        s3_re_nxt = SW'(s2_ar_r) - SW'(s2_br_r);
        s3_im_nxt = SW'(s2_ai_r) - SW'(s2_bi_r);
      end
      OP_MUL: begin
        s3_re_nxt = SW'(s2_m0_r) - SW'(s2_m1_r);
        s3_im_nxt = SW'(s2_m2_r) + SW'(s2_m3_r);
      end
      OP_SCALE: begin
        s3_re_nxt = SW'(s2_m0_r);
        s3_im_nxt = SW'(s2_m1_r);
      end
      OP_CONJ, OP_RECIP: begin
        s3_re_nxt = SW'(s2_ar_r);
        s3_im_nxt = -SW'(s2_ai_r);
      end
      OP_DIV: begin
        s3_re_nxt = SW'(s2_m0_r) + SW'(s2_m1_r);
        s3_im_nxt = SW'(s2_m3_r) - SW'(s2_m2_r);
      end
      default: begin
        s3_re_nxt = '0;
        s3_im_nxt = '0;
      end
    endcase
    if (s2_op_r == OP_RECIP) den_sum = SW'(s2_m0_r) + SW'(s2_m1_r);
    else                     den_sum = SW'(s2_m4_r) + SW'(s2_m5_r);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_op_r  <= s2_op_r;
      s3_re_r  <= s3_re_nxt;
      s3_im_r  <= s3_im_nxt;
      s3_den_r <= den_sum[DW-1:0];
    end
  end

  // divider stage 0: magnitudes, signs and truncating shifts
  always_comb begin
    logic [SW-1:0] re_mag, im_mag;
    logic [RW-1:0] re_ext, im_ext;
    re_mag = s3_re_r[SW-1] ? -s3_re_r : s3_re_r;
    im_mag = s3_im_r[SW-1] ? -s3_im_r : s3_im_r;
    re_ext = {{(RW-SW){1'b0}}, re_mag};
    im_ext = {{(RW-SW){1'b0}}, im_mag};
    dp0_nxt        = '0;
    dp0_nxt.is_div = (s3_op_r == OP_DIV) || (s3_op_r == OP_RECIP);
    dp0_nxt.den    = s3_den_r;
    dp0_nxt.dz     = dp0_nxt.is_div && (s3_den_r == '0);
    dp0_nxt.re_neg = s3_re_r[SW-1];
    dp0_nxt.im_neg = s3_im_r[SW-1];
    dp0_nxt.re_v   = s3_re_r;
    dp0_nxt.im_v   = s3_im_r;
    case (s3_op_r)
      OP_MUL, OP_SCALE: begin
        dp0_nxt.re_v = trunc_f(s3_re_r);
        dp0_nxt.im_v = trunc_f(s3_im_r);
      end
      OP_RECIP: begin
        dp0_nxt.re_r = re_ext << (2*F);
        dp0_nxt.im_r = im_ext << (2*F);
      end
      OP_DIV: begin
        dp0_nxt.re_r = re_ext << F;
        dp0_nxt.im_r = im_ext << F;
      end
      default: ;
    endcase
  end

  // divider stage 1: quotient beyond the word
  always_comb begin
    logic [RW-1:0] lim;
    lim            = {{(RW-DW){1'b0}}, dp_r[0].den} << W;
    dp1_nxt        = dp_r[0];
    dp1_nxt.re_big = dp_r[0].is_div && (dp_r[0].re_r >= lim);
    dp1_nxt.im_big = dp_r[0].is_div && (dp_r[0].im_r >= lim);
  end

  always_ff @(posedge clk) begin
    if (dp_rdy[0] && s3_v_r) dp_r[0] <= dp0_nxt;
    if (dp_rdy[1] && dv_r[0]) dp_r[1] <= dp1_nxt;
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 2; j <= W + 1; j++) begin : g_div
    localparam int K = W + 1 - j;
    dp_t dp_nxt;
    always_comb begin
      logic [RW-1:0] t;
      t      = {{(RW-DW){1'b0}}, dp_r[j-1].den} << K;
      dp_nxt = dp_r[j-1];
      if (dp_r[j-1].re_r >= t) begin
        dp_nxt.re_r    = dp_r[j-1].re_r - t;
        dp_nxt.re_q[K] = 1'b1;
      end
      if (dp_r[j-1].im_r >= t) begin
        dp_nxt.im_r    = dp_r[j-1].im_r - t;
        dp_nxt.im_q[K] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (dp_rdy[j] && dv_r[j-1]) dp_r[j] <= dp_nxt;
    end
  end

  // output: sign, saturation, flags
  assign sat_re = sat_f(fin_f(dp_r[W+1].is_div, dp_r[W+1].dz, dp_r[W+1].re_neg,
                              dp_r[W+1].re_big, dp_r[W+1].re_q, dp_r[W+1].re_v));
  assign sat_im = sat_f(fin_f(dp_r[W+1].is_div, dp_r[W+1].dz, dp_r[W+1].im_neg,
                              dp_r[W+1].im_big, dp_r[W+1].im_q, dp_r[W+1].im_v));

  always_ff @(posedge clk) begin
    if (rdy_out && dv_r[W+1]) begin
      out_data_r <= OUT_DW'({sat_im[W-1:0], sat_re[W-1:0]});
      out_user_r <= {dp_r[W+1].dz, sat_re[W] | sat_im[W]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/core/cau_checker.sv =====
// Port-level checks for complex_arithmetic_unit, bound into every instance of it.
// Depends on complex_arithmetic_unit_macros.svh.
`include "complex_arithmetic_unit_macros.svh"

module cau_checker #(
  parameter int WORD_WIDTH = 32
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*WORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  input logic [1:0]                           out_tuser
);

  localparam int W = WORD_WIDTH;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = ~SMAX;

  logic [W-1:0] res_re, res_im;

  assign res_re = out_tdata[W-1:0];
  assign res_im = out_tdata[2*W-1:W];

  `CAU_CHECK_RST(a_reset_empty, !rst_n |=> !out_tvalid && in_tready, "pipe not empty after reset")
  `CAU_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled item changed")
  `CAU_CHECK(a_dz_zero, out_tvalid && out_tuser[1] |-> res_re == '0 && res_im == '0 && !out_tuser[0], "zero divisor item not cleared")
  `CAU_CHECK(a_ov_bound, out_tvalid && out_tuser[0] |-> res_re == SMAX || res_re == SMIN || res_im == SMAX || res_im == SMIN, "overflow without saturated part")

endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_WIDTH(WORD_WIDTH)) u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== bench/complex_arithmetic_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the complex arithmetic unit: watches both stream channels, predicts each result
// in 128-bit signed arithmetic and compares field by field. Depends on cau_pkg.
module complex_arithmetic_unit_checker
  import cau_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           errors,
  output int           pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } cplx_result_t;

  cplx_result_t awaited_results[$];
  int           results_seen;

  initial errors = 0;
  initial results_seen = 0;
  assign pending = awaited_results.size();

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at result %0d: %s", results_seen, what);
  endtask

  function automatic logic [31:0] clamp_word(input wide_t v, inout logic ovf);
    if (v > wide_t'(32'sh7fffffff)) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic cplx_result_t compute_result(input logic [2:0] op,
                                                  input logic [159:0] d);
    wide_t        ar, ai, br, bi, sf, re, im, den;
    cplx_result_t r;
    logic         ovf;
    ar = wide_t'($signed(d[31:0]));
    ai = wide_t'($signed(d[63:32]));
    br = wide_t'($signed(d[95:64]));
    bi = wide_t'($signed(d[127:96]));
    sf = wide_t'($signed(d[159:128]));
    re = 0;
    im = 0;
    ovf = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi) / 65536;
        im = (ar * bi + ai * br) / 65536;
      end
      OP_SCALE: begin
        re = (sf * ar) / 65536;
        im = (sf * ai) / 65536;
      end
      OP_CONJ: begin
        re = ar;
        im = -ai;
      end
      OP_RECIP: begin
        den = ar * ar + ai * ai;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = (ar <<< 32) / den;
          im = ((-ai) <<< 32) / den;
        end
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = ((ar * br + ai * bi) <<< 16) / den;
          im = ((ai * br - ar * bi) <<< 16) / den;
        end
      end
      default: ;
    endcase
    r.re = clamp_word(re, ovf);
    r.im = clamp_word(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    cplx_result_t want;
    if (rst_n && in_tvalid && in_tready)
      awaited_results.push_back(compute_result(in_tuser, in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0)
        report_mismatch("result with nothing outstanding");
      else begin
        want = awaited_results.pop_front();
        if (out_tdata[31:0] !== want.re)
          report_mismatch($sformatf("result_re %h, want %h", out_tdata[31:0], want.re));
        if (out_tdata[63:32] !== want.im)
          report_mismatch($sformatf("result_im %h, want %h", out_tdata[63:32], want.im));
        if (out_tuser[0] !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", out_tuser[0], want.ovf));
        if (out_tuser[1] !== want.dz)
          report_mismatch($sformatf("divide_by_zero %b, want %b", out_tuser[1], want.dz));
      end
      results_seen++;
    end
  end

endmodule

// ===== bench/complex_arithmetic_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the complex arithmetic unit bench: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit and complex_arithmetic_unit_checker.
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [2:0] OP_SPARE = 3'd7;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;

  int errors, pending;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int hold_req = 0, hold_left = 0;
  int cycles = 0, items_sent = 0;
  int op_count[8];

  always #2 clk = ~clk;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  complex_arithmetic_unit_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold when requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_item(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi,
                           input logic [31:0] sf);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {sf, bi, br, ai, ar};
    in_tuser <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    op_count[op]++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0]  op;
    logic [31:0] br, bi;
    op = 3'($urandom_range(0, 7));
    br = pick_word();
    bi = pick_word();
    if ($urandom_range(0, 15) == 0) begin
      br = 0;
      bi = 0;
    end
    send_item(op, pick_word(), pick_word(), br, bi, pick_word());
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every operation, zero divisors, most negative conjugate
    send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_item(OP_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000, 0);
    send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send_item(OP_SUB, 32'h00030000, 32'h0, 32'h00010000, 32'h00010000, 0);
    send_item(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_item(OP_MUL, 32'h00020000, 32'h00010000, 32'hfffe0000, 32'h00008000, 0);
    send_item(OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff, 0);
    send_item(OP_SCALE, 32'h7fffffff, 32'h80000000, 0, 0, 32'h80000000);
    send_item(OP_SCALE, 32'h00010000, 32'hffff8000, 0, 0, 32'hffff0000);
    send_item(OP_SCALE, 32'hffffffff, 32'h1, 0, 0, 32'h00008000);
    send_item(OP_CONJ, 32'h80000000, 32'h80000000, 0, 0, 0);
    send_item(OP_CONJ, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_item(OP_RECIP, 0, 0, 32'h00010000, 0, 0);
    send_item(OP_RECIP, 32'h00010000, 0, 0, 0, 0);
    send_item(OP_RECIP, 32'h1, 32'hffffffff, 0, 0, 0);
    send_item(OP_RECIP, 32'h80000000, 32'h80000000, 0, 0, 0);
    send_item(OP_DIV, 32'h00010000, 32'h00010000, 0, 0, 0);
    send_item(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 0, 0);
    send_item(OP_DIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'hffff0000, 0);
    send_item(OP_DIV, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 0);
    send_item(OP_SPARE, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1, 32'hffffffff);

    // sender mostly busy, receiver mostly stalled; long hold to fill the pipe
    tx_idle_pct = 19;
    rx_idle_pct = 69;
    hold_req = 400;
    repeat (560) send_random();

    // pause until the pipeline has drained
    in_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    tx_idle_pct = 69;
    rx_idle_pct = 19;
    repeat (560) send_random();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (560) send_random();

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);

    $display("covered %0d items: add %0d sub %0d mul %0d scale %0d conj %0d recip %0d div %0d",
             items_sent, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
             op_count[5], op_count[6]);
    $display("spare code %0d, stalls on both sides, %0d cycles", op_count[7], cycles);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
